FILE: rtl/gtr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gtr_pkg;

    // Field widths of the stream words.
    localparam int COORD_BITS = 12;
    localparam int SCALE_BITS = 8;
    localparam int COLOR_BITS = 16;
    localparam int CODE_BITS  = 8;

    // Coordinates plus a few dot offsets never exceed this width.
    localparam int EXT_BITS = COORD_BITS + 2;

    localparam int IN_TDATA_W  = 2 * COORD_BITS + SCALE_BITS + COLOR_BITS + CODE_BITS;
    localparam int OUT_TDATA_W = 4 * COORD_BITS + COLOR_BITS;

    // Glyph geometry.
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_DOTS = GLYPH_COLS * GLYPH_ROWS;
    localparam int ADVANCE    = 6;
    localparam int POS_BITS   = $clog2(GLYPH_ROWS);

    // Geometry tables: one entry per glyph column or row.
    localparam int GEOM_DEPTH  = 8;
    localparam int GEOM_AW     = $clog2(GEOM_DEPTH);
    localparam int GEOM_DATA_W = 2 * COORD_BITS;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd480;
    localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd320;

    // Character codes handled by the font.
    localparam logic [CODE_BITS-1:0] CODE_END     = 8'h00;
    localparam logic [CODE_BITS-1:0] LOWER_A      = 8'h61;
    localparam logic [CODE_BITS-1:0] LOWER_Z      = 8'h7A;
    localparam logic [CODE_BITS-1:0] CASE_OFFSET  = 8'h20;

    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] t_glyph;

    typedef enum logic [1:0] {
        G_IDLE,
        G_DECODE,
        G_LOAD,
        G_WAIT
    } t_geom_state;

    typedef enum logic {
        E_IDLE,
        E_SCAN
    } t_emit_state;

    typedef struct packed {
        logic                   en;
        logic [GEOM_AW-1:0]     addr;
        logic [GEOM_DATA_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic                  start;
        logic [GLYPH_DOTS-1:0] mask;
    } t_emit_cmd;

    // Five column bytes, column 0 first; bit 0 of a byte is the top row.
    function automatic t_glyph glyph_cols(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2, input logic [7:0] c3,
                                          input logic [7:0] c4);
        glyph_cols = {c4[GLYPH_ROWS-1:0], c3[GLYPH_ROWS-1:0], c2[GLYPH_ROWS-1:0],
                      c1[GLYPH_ROWS-1:0], c0[GLYPH_ROWS-1:0]};
    endfunction

    function automatic t_glyph glyph_lookup(input logic [CODE_BITS-1:0] code);
        logic [CODE_BITS-1:0] c;
        t_glyph               g;
        c = code;
        if (code >= LOWER_A && code <= LOWER_Z) begin
            c = code - CASE_OFFSET;
        end
        case (c)
            8'h41: g = glyph_cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);  // A
            8'h42: g = glyph_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g = glyph_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g = glyph_cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            8'h45: g = glyph_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g = glyph_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g = glyph_cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
            8'h48: g = glyph_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: g = glyph_cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4A: g = glyph_cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            8'h4B: g = glyph_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: g = glyph_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: g = glyph_cols(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E: g = glyph_cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F: g = glyph_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: g = glyph_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: g = glyph_cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52: g = glyph_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g = glyph_cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54: g = glyph_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55: g = glyph_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: g = glyph_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: g = glyph_cols(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            8'h58: g = glyph_cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: g = glyph_cols(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
            8'h5A: g = glyph_cols(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);  // Z
            8'h30: g = glyph_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);  // 0
            8'h31: g = glyph_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32: g = glyph_cols(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            8'h33: g = glyph_cols(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
            8'h34: g = glyph_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35: g = glyph_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36: g = glyph_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            8'h37: g = glyph_cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38: g = glyph_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g = glyph_cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);  // 9
            8'h2F: g = glyph_cols(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);  // slash
            8'h2E: g = glyph_cols(8'h00, 8'h00, 8'h60, 8'h00, 8'h00);  // period
            8'h3A: g = glyph_cols(8'h00, 8'h00, 8'h36, 8'h00, 8'h00);  // colon
            8'h2D: g = glyph_cols(8'h00, 8'h00, 8'h08, 8'h00, 8'h00);  // minus
            8'h7C: g = glyph_cols(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);  // bar
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gtr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gtr_ram #(
    parameter int WIDTH = gtr_pkg::GEOM_DATA_W,
    parameter int DEPTH = gtr_pkg::GEOM_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/gtr_geom.sv
`timescale 1ns / 1ps
`default_nettype none

module gtr_geom (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [gtr_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  wire logic                                i_s_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gtr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [gtr_pkg::COORD_BITS-1:0]      i_cfg_data,
    input  wire logic                                i_emit_busy,
    output gtr_pkg::t_ram_wr                         o_col_wr,
    output gtr_pkg::t_ram_wr                         o_row_wr,
    output gtr_pkg::t_emit_cmd                       o_cmd,
    output logic      [gtr_pkg::COLOR_BITS-1:0]      o_color
);

    localparam int CB = gtr_pkg::COORD_BITS;
    localparam int EB = gtr_pkg::EXT_BITS;
    localparam int SB = gtr_pkg::SCALE_BITS;
    localparam int KB = gtr_pkg::POS_BITS;

    gtr_pkg::t_geom_state r_state, n_state;

    // Latched input word.
    logic                           r_run_start;
    logic [CB-1:0]                  r_start_x;
    logic [CB-1:0]                  r_start_y;
    logic [SB-1:0]                  r_in_scale;
    logic [gtr_pkg::COLOR_BITS-1:0] r_in_color;
    logic [gtr_pkg::CODE_BITS-1:0]  r_code;

    // Run context.
    logic [CB-1:0]                  r_cursor;
    logic [CB-1:0]                  r_line;
    logic [SB-1:0]                  r_scale;
    logic [gtr_pkg::COLOR_BITS-1:0] r_color;
    logic                           r_ended;

    logic [CB-1:0] r_width;
    logic [CB-1:0] r_height;

    gtr_pkg::t_glyph                r_glyph;
    logic [EB-1:0]                  r_xacc;
    logic [EB-1:0]                  r_yacc;
    logic [KB-1:0]                  r_k;
    logic [gtr_pkg::GLYPH_COLS-1:0] r_colvis;
    logic [gtr_pkg::GLYPH_ROWS-1:0] r_rowvis;

    logic [CB-1:0] eff_cursor;
    logic [CB-1:0] eff_line;
    logic [SB-1:0] eff_scale;
    logic          eff_ended;
    logic [EB-1:0] step;
    logic [EB-1:0] sum;
    logic          stop;

    logic          x_vis, y_vis;
    logic [EB-1:0] x1_raw, y1_raw, x1_clip, y1_clip;
    logic          load_last;
    logic [gtr_pkg::GLYPH_ROWS-1:0] rowvis_full;
    logic [gtr_pkg::GLYPH_DOTS-1:0] mask;

    // Decode of the latched item against the run context.
    always_comb begin
        eff_cursor = r_run_start ? r_start_x  : r_cursor;
        eff_line   = r_run_start ? r_start_y  : r_line;
        eff_scale  = r_run_start ? r_in_scale : r_scale;
        eff_ended  = r_run_start ? 1'b0       : r_ended;
        step       = EB'(eff_scale) * EB'(gtr_pkg::ADVANCE);
        sum        = EB'(eff_cursor) + step;
        stop       = (r_code == gtr_pkg::CODE_END) || (sum >= EB'(r_width));
    end

    // Per column / row placement and clipping.
    always_comb begin
        x_vis   = r_xacc < EB'(r_width);
        y_vis   = r_yacc < EB'(r_height);
        x1_raw  = r_xacc + EB'(r_scale) - EB'(1);
        y1_raw  = r_yacc + EB'(r_scale) - EB'(1);
        x1_clip = (x1_raw >= EB'(r_width))  ? EB'(r_width)  - EB'(1) : x1_raw;
        y1_clip = (y1_raw >= EB'(r_height)) ? EB'(r_height) - EB'(1) : y1_raw;
        load_last   = r_k == KB'(gtr_pkg::GLYPH_ROWS - 1);
        rowvis_full = {y_vis, r_rowvis[gtr_pkg::GLYPH_ROWS-2:0]};
        for (int c = 0; c < gtr_pkg::GLYPH_COLS; c++) begin
            for (int r = 0; r < gtr_pkg::GLYPH_ROWS; r++) begin
                mask[c*gtr_pkg::GLYPH_ROWS + r] = r_glyph[c][r] & r_colvis[c] & rowvis_full[r];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtr_pkg::G_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = gtr_pkg::G_DECODE;
                end
            end
            gtr_pkg::G_DECODE: begin
                if (eff_ended || stop || eff_scale == '0) begin
                    n_state = gtr_pkg::G_IDLE;
                end else begin
                    n_state = gtr_pkg::G_LOAD;
                end
            end
            gtr_pkg::G_LOAD: begin
                if (load_last) begin
                    n_state = (mask == '0) ? gtr_pkg::G_IDLE : gtr_pkg::G_WAIT;
                end
            end
            gtr_pkg::G_WAIT: begin
                if (!i_emit_busy) begin
                    n_state = gtr_pkg::G_IDLE;
                end
            end
            default: n_state = gtr_pkg::G_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = r_state == gtr_pkg::G_IDLE;
        o_cfg_ready    = 1'b1;
        o_col_wr.en    = (r_state == gtr_pkg::G_LOAD) && (r_k < KB'(gtr_pkg::GLYPH_COLS));
        o_col_wr.addr  = gtr_pkg::GEOM_AW'(r_k);
        o_col_wr.data  = {x1_clip[CB-1:0], r_xacc[CB-1:0]};
        o_row_wr.en    = r_state == gtr_pkg::G_LOAD;
        o_row_wr.addr  = gtr_pkg::GEOM_AW'(r_k);
        o_row_wr.data  = {y1_clip[CB-1:0], r_yacc[CB-1:0]};
        o_cmd.start    = (r_state == gtr_pkg::G_LOAD) && load_last && (mask != '0);
        o_cmd.mask     = mask;
        o_color        = r_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gtr_pkg::G_IDLE;
            r_cursor <= '0;
            r_line   <= '0;
            r_scale  <= '0;
            r_color  <= '0;
            r_ended  <= 1'b1;
            r_width  <= gtr_pkg::SCREEN_WIDTH_RESET;
            r_height <= gtr_pkg::SCREEN_HEIGHT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gtr_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    gtr_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == gtr_pkg::G_DECODE) begin
                if (r_run_start) begin
                    r_line   <= r_start_y;
                    r_scale  <= r_in_scale;
                    r_color  <= r_in_color;
                end
                // A start word opens the run before its own character is judged.
                if (!eff_ended) begin
                    r_ended  <= stop;
                    r_cursor <= stop ? eff_cursor : sum[CB-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_run_start <= i_s_tuser;
            r_start_x   <= i_s_tdata[CB-1:0];
            r_start_y   <= i_s_tdata[2*CB-1:CB];
            r_in_scale  <= i_s_tdata[2*CB+SB-1:2*CB];
            r_in_color  <= i_s_tdata[2*CB+SB+gtr_pkg::COLOR_BITS-1:2*CB+SB];
            r_code      <= i_s_tdata[gtr_pkg::IN_TDATA_W-1:2*CB+SB+gtr_pkg::COLOR_BITS];
        end
        if (r_state == gtr_pkg::G_DECODE) begin
            r_glyph <= gtr_pkg::glyph_lookup(r_code);
            r_xacc  <= EB'(eff_cursor);
            r_yacc  <= EB'(eff_line);
            r_k     <= '0;
        end
        if (r_state == gtr_pkg::G_LOAD) begin
            r_xacc <= r_xacc + EB'(r_scale);
            r_yacc <= r_yacc + EB'(r_scale);
            r_k    <= r_k + KB'(1);
            if (r_k < KB'(gtr_pkg::GLYPH_COLS)) begin
                r_colvis[r_k] <= x_vis;
            end
            r_rowvis[r_k] <= y_vis;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gtr_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module gtr_emit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire gtr_pkg::t_emit_cmd                  i_cmd,
    input  wire logic [gtr_pkg::COLOR_BITS-1:0]      i_color,
    input  wire logic [gtr_pkg::GEOM_DATA_W-1:0]     i_col_rd_data,
    input  wire logic [gtr_pkg::GEOM_DATA_W-1:0]     i_row_rd_data,
    output logic      [gtr_pkg::GEOM_AW-1:0]         o_col_rd_addr,
    output logic      [gtr_pkg::GEOM_AW-1:0]         o_row_rd_addr,
    output logic                                     o_busy,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic      [gtr_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                     o_m_tlast
);

    localparam int KB = gtr_pkg::POS_BITS;
    localparam int ND = gtr_pkg::GLYPH_DOTS;

    gtr_pkg::t_emit_state r_state, n_state;

    logic [KB-1:0] r_col, n_col;
    logic [KB-1:0] r_row, n_row;
    logic [ND-1:0] r_rem;
    logic          r_valid;
    logic          adv;
    logic          tail_zero;

    // The RAM output always belongs to the dot at r_col/r_row, so the read
    // address is the position that will be current after this edge.
    always_comb begin
        adv       = !r_valid || i_m_tready;
        tail_zero = r_rem[ND-1:1] == '0;
        n_col     = '0;
        n_row     = '0;
        if (r_state == gtr_pkg::E_SCAN) begin
            if (!adv) begin
                n_col = r_col;
                n_row = r_row;
            end else if (!tail_zero) begin
                if (r_row == KB'(gtr_pkg::GLYPH_ROWS - 1)) begin
                    n_col = r_col + KB'(1);
                end else begin
                    n_col = r_col;
                    n_row = r_row + KB'(1);
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtr_pkg::E_IDLE: begin
                if (i_cmd.start) begin
                    n_state = gtr_pkg::E_SCAN;
                end
            end
            gtr_pkg::E_SCAN: begin
                if (adv && tail_zero) begin
                    n_state = gtr_pkg::E_IDLE;
                end
            end
            default: n_state = gtr_pkg::E_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = r_state == gtr_pkg::E_SCAN;
        o_col_rd_addr = gtr_pkg::GEOM_AW'(n_col);
        o_row_rd_addr = gtr_pkg::GEOM_AW'(n_row);
        o_m_tvalid    = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtr_pkg::E_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (r_state == gtr_pkg::E_SCAN && adv) begin
                r_valid <= r_rem[0];
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gtr_pkg::E_IDLE && i_cmd.start) begin
            r_rem <= i_cmd.mask;
        end else if (r_state == gtr_pkg::E_SCAN && adv) begin
            r_rem <= r_rem >> 1;
        end
        if (r_state == gtr_pkg::E_SCAN && adv && r_rem[0]) begin
            o_m_tdata <= {i_color,
                          i_row_rd_data[gtr_pkg::GEOM_DATA_W-1:gtr_pkg::COORD_BITS],
                          i_col_rd_data[gtr_pkg::GEOM_DATA_W-1:gtr_pkg::COORD_BITS],
                          i_row_rd_data[gtr_pkg::COORD_BITS-1:0],
                          i_col_rd_data[gtr_pkg::COORD_BITS-1:0]};
            o_m_tlast <= tail_zero;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/glyph_text_rect_rasterizer.sv
// Text rasterizer with a built-in 5x7 font. Each input word carries one
// character; a word with tuser set first latches the start position, dot
// scale and color of a new run. Each set dot on the screen leaves as one
// output word: an inclusive window x0,y0,x1,y1 of scale by scale pixels,
// clipped to the screen, with the run color, and tlast on the last window of
// the character. Dots go out column by column, top to bottom in a column.
// Lowercase letters fold to uppercase; codes without a glyph draw nothing
// but still advance the cursor by six dots. A zero code, or a character
// whose cell would reach the right screen edge, ends the run, and words
// without tuser are dropped until the next start. The screen size is set
// through the configuration port (index 0 width, index 1 height, reset
// 480 by 320) and may only be written while the block is idle.
// Timing: one word is in work at a time. A word that is dropped, ends the
// run or has a zero scale goes from decode straight back to idle. Any other
// character is decoded and then has its seven rows and five columns placed
// into the geometry tables; one that then has no visible dot goes back to
// idle. One that draws scans one dot position per cycle while the output is
// not stalled, up to the last drawn dot (at most 35 positions), then hands
// back to the decoder, which takes the next word. The dot scan reads each
// geometry table through its single read port; a stalled output holds the
// scan in place, and a finished window can wait in the output register
// while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module glyph_text_rect_rasterizer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Slave side.
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata, lowest bit first: start_x[11:0], start_y[23:12],
    // text_scale[31:24], text_color[47:32], char_code[55:48].
    input  wire logic [gtr_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // tuser: run_start.
    input  wire logic                                i_s_tuser,
    // Master side.
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata, lowest bit first: rect_x0[11:0], rect_y0[23:12],
    // rect_x1[35:24], rect_y1[47:36], rect_color[63:48].
    output logic      [gtr_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // tlast: last_of_char.
    output logic                                     o_m_tlast,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gtr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [gtr_pkg::COORD_BITS-1:0]      i_cfg_data
);

    gtr_pkg::t_ram_wr   col_wr;
    gtr_pkg::t_ram_wr   row_wr;
    gtr_pkg::t_emit_cmd cmd;

    logic [gtr_pkg::COLOR_BITS-1:0]  color;
    logic                            emit_busy;
    logic [gtr_pkg::GEOM_AW-1:0]     col_rd_addr;
    logic [gtr_pkg::GEOM_AW-1:0]     row_rd_addr;
    logic [gtr_pkg::GEOM_DATA_W-1:0] col_rd_data;
    logic [gtr_pkg::GEOM_DATA_W-1:0] row_rd_data;

    // Decode, run context and per-column / per-row placement.
    gtr_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_emit_busy (emit_busy),
        .o_col_wr    (col_wr),
        .o_row_wr    (row_wr),
        .o_cmd       (cmd),
        .o_color     (color)
    );

    // Column table: clipped x0 and x1 of each glyph column.
    gtr_ram #(
        .WIDTH (gtr_pkg::GEOM_DATA_W),
        .DEPTH (gtr_pkg::GEOM_DEPTH)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (col_wr.en),
        .i_wr_addr (col_wr.addr),
        .i_wr_data (col_wr.data),
        .i_rd_addr (col_rd_addr),
        .o_rd_data (col_rd_data)
    );

    // Row table: clipped y0 and y1 of each glyph row.
    gtr_ram #(
        .WIDTH (gtr_pkg::GEOM_DATA_W),
        .DEPTH (gtr_pkg::GEOM_DEPTH)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (row_wr.en),
        .i_wr_addr (row_wr.addr),
        .i_wr_data (row_wr.data),
        .i_rd_addr (row_rd_addr),
        .o_rd_data (row_rd_data)
    );

    // Dot scan and output register.
    gtr_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_color       (color),
        .i_col_rd_data (col_rd_data),
        .i_row_rd_data (row_rd_data),
        .o_col_rd_addr (col_rd_addr),
        .o_row_rd_addr (row_rd_addr),
        .o_busy        (emit_busy),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/gtr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gtr_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_s_tvalid,
    input wire logic                                o_s_tready,
    input wire logic                                o_m_tvalid,
    input wire logic                                i_m_tready,
    input wire logic [gtr_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input wire logic                                o_m_tlast
);

    localparam int CB = gtr_pkg::COORD_BITS;

    // After reset the block takes input and shows no window.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_tready && !o_m_tvalid))
        else $error("block not idle after reset");

    // A word is worked on alone: the input closes right after acceptance.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input still open after acceptance");

    // A clipped window is never empty or inverted.
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[CB-1:0] <= o_m_tdata[3*CB-1:2*CB]) &&
                       (o_m_tdata[2*CB-1:CB] <= o_m_tdata[4*CB-1:3*CB]))
        else $error("window corners out of order");

    // A stalled window holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled output word changed");

endmodule

bind glyph_text_rect_rasterizer gtr_checker u_gtr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast)
);

`default_nettype wire
